### design/ihx_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the HEX record parser.
// Used by the front, the command queue, the back and the top level.
package ihx_pkg;

  localparam int HDR_BYTES = 5;
  localparam int DATA_OFS  = 4;
  localparam int QDEPTH    = 2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_ODD     = 3'd0;
  localparam logic [2:0] ERR_SUM     = 3'd1;
  localparam logic [2:0] ERR_SHORT   = 3'd2;
  localparam logic [2:0] ERR_LEN     = 3'd3;
  localparam logic [2:0] ERR_CHAR    = 3'd4;
  localparam logic [2:0] ERR_LONG    = 3'd5;
  localparam logic [2:0] ERR_UNARMED = 3'd6;

  localparam logic REQ_CHAR  = 1'b0;
  localparam logic REQ_BEGIN = 1'b1;

  typedef enum logic [1:0] {
    PH_HI,
    PH_LO,
    PH_TRAILER,
    PH_ERROR
  } phase_t;

  typedef enum logic {
    B_IDLE,
    B_DATA
  } bstate_t;

  typedef struct packed {
    logic        is_err;
    logic [2:0]  code;
    logic [7:0]  rtype;
    logic [7:0]  len;
    logic [15:0] addr;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  record_type;
    logic [5:0]  record_length;
    logic [15:0] load_address;
    logic [7:0]  data_value;
    logic [5:0]  byte_index;
    logic        last;
    logic [2:0]  error_code;
  } res_t;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

### design/ihx_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the HEX record parser: character input and results.
// Depends on nothing.
interface ihx_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_char;

  modport source(output valid, req_type, rx_char, input ready);
  modport sink(input valid, req_type, rx_char, output ready);
endinterface

interface ihx_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  record_type;
  logic [5:0]  record_length;
  logic [15:0] load_address;
  logic [7:0]  data_value;
  logic [5:0]  byte_index;
  logic        last;
  logic [2:0]  error_code;

  modport source(output valid, kind, record_type, record_length, load_address,
                 data_value, byte_index, last, error_code, input ready);
  modport sink(input valid, kind, record_type, record_length, load_address,
               data_value, byte_index, last, error_code, output ready);
endinterface

### design/ihx_front.sv
`timescale 1ns / 1ps
// Front of the parser: takes characters, tracks the line and error state,
// writes the line store and queues commands. Depends on ihx_pkg and ihx_in_if.
module ihx_front #(
  parameter int LINE_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ihx_in_if.sink                          in_ch,
  input  logic                            cmd_full,
  input  logic                            rec_done,
  output logic                            cmd_push,
  output ihx_pkg::cmd_t                   cmd_data,
  output logic                            mem_we,
  output logic [$clog2(LINE_BYTES)-1:0]   mem_waddr,
  output logic [7:0]                      mem_wdata,
  output logic                            rec_pending
);

  localparam int BRW = $clog2(LINE_BYTES + 1);
  localparam int AW  = $clog2(LINE_BYTES);
  localparam int CW  = (BRW > 8) ? BRW : 8;

  logic [BRW-1:0]  br_r, br_nxt;
  ihx_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic            err_seen_r, err_seen_nxt;
  logic            armed_r, armed_nxt;
  logic            inside_r, inside_nxt;
  logic            rec_pend_r, rec_pend_nxt;
  logic [3:0]      hi_nib_r, hi_nib_nxt;
  logic [7:0]      hdr_r [4];
  logic            hdr_we;

  logic            accept;
  logic [4:0]      hv;
  logic [7:0]      byte_val;
  logic            err_hit;
  logic [2:0]      err_code;
  logic            len_bad;

  assign in_ch.ready = !cmd_full && !rec_pend_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign hv          = ihx_pkg::hex_val(in_ch.rx_char);
  assign byte_val    = {hi_nib_r, hv[3:0]};
  assign len_bad     = (CW'(br_r) - CW'(ihx_pkg::HDR_BYTES)) != CW'(hdr_r[0]);
  assign rec_pending = rec_pend_r;
  assign mem_wdata   = byte_val;
  assign mem_waddr   = br_r[AW-1:0];

  always_comb begin
    br_nxt       = br_r;
    phase_nxt    = phase_r;
    sum_nxt      = sum_r;
    err_seen_nxt = err_seen_r;
    armed_nxt    = armed_r;
    inside_nxt   = inside_r;
    hi_nib_nxt   = hi_nib_r;
    rec_pend_nxt = rec_pend_r && !rec_done;
    cmd_push     = 1'b0;
    cmd_data     = '0;
    mem_we       = 1'b0;
    hdr_we       = 1'b0;
    err_hit      = 1'b0;
    err_code     = ihx_pkg::ERR_ODD;
    if (accept) begin
      if (in_ch.req_type == ihx_pkg::REQ_BEGIN) begin
        err_seen_nxt = 1'b0;
        armed_nxt    = 1'b1;
      end else if (!inside_r) begin
        if (in_ch.rx_char == ihx_pkg::CH_COLON) begin
          inside_nxt = 1'b1;
          br_nxt     = '0;
          sum_nxt    = '0;
          phase_nxt  = ihx_pkg::PH_HI;
        end
      end else if (in_ch.rx_char == ihx_pkg::CH_CR || in_ch.rx_char == ihx_pkg::CH_LF) begin
        inside_nxt = 1'b0;
        if (phase_r == ihx_pkg::PH_LO) begin
          err_hit  = 1'b1;
          err_code = ihx_pkg::ERR_ODD;
        end else if (sum_r != 8'd0) begin
          err_hit  = 1'b1;
          err_code = ihx_pkg::ERR_SUM;
        end else if (br_r < BRW'(ihx_pkg::HDR_BYTES)) begin
          err_hit  = 1'b1;
          err_code = ihx_pkg::ERR_SHORT;
        end else if (len_bad) begin
          err_hit  = 1'b1;
          err_code = ihx_pkg::ERR_LEN;
        end else if (!err_seen_r && !armed_r) begin
          err_hit  = 1'b1;
          err_code = ihx_pkg::ERR_UNARMED;
        end else if (!err_seen_r) begin
          cmd_push      = 1'b1;
          cmd_data.rtype = hdr_r[3];
          cmd_data.len   = hdr_r[0];
          cmd_data.addr  = {hdr_r[1], hdr_r[2]};
          rec_pend_nxt   = 1'b1;
        end
      end else if (in_ch.rx_char == ihx_pkg::CH_SPACE ||
                   in_ch.rx_char == ihx_pkg::CH_TAB) begin
        if (phase_r == ihx_pkg::PH_LO) begin
          err_hit  = 1'b1;
          err_code = ihx_pkg::ERR_ODD;
        end
        phase_nxt = ihx_pkg::PH_TRAILER;
      end else if (!hv[4]) begin
        err_hit  = 1'b1;
        err_code = ihx_pkg::ERR_CHAR;
      end else begin
        case (phase_r)
          ihx_pkg::PH_HI: begin
            if (br_r >= BRW'(LINE_BYTES)) begin
              phase_nxt = ihx_pkg::PH_ERROR;
              err_hit   = 1'b1;
              err_code  = ihx_pkg::ERR_LONG;
            end else begin
              hi_nib_nxt = hv[3:0];
              phase_nxt  = ihx_pkg::PH_LO;
            end
          end
          ihx_pkg::PH_LO: begin
            if (br_r < BRW'(LINE_BYTES)) begin
              mem_we  = 1'b1;
              hdr_we  = br_r < BRW'(4);
              sum_nxt = sum_r + byte_val;
              br_nxt  = br_r + BRW'(1);
            end
            phase_nxt = ihx_pkg::PH_HI;
          end
          default: begin
            phase_nxt = ihx_pkg::PH_ERROR;
            err_hit   = 1'b1;
            err_code  = ihx_pkg::ERR_CHAR;
          end
        endcase
      end
      if (err_hit) begin
        if (!err_seen_r) begin
          cmd_push       = 1'b1;
          cmd_data.is_err = 1'b1;
          cmd_data.code   = err_code;
        end
        err_seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      br_r       <= '0;
      phase_r    <= ihx_pkg::PH_HI;
      sum_r      <= '0;
      err_seen_r <= 1'b0;
      armed_r    <= 1'b0;
      inside_r   <= 1'b0;
      rec_pend_r <= 1'b0;
    end else begin
      br_r       <= br_nxt;
      phase_r    <= phase_nxt;
      sum_r      <= sum_nxt;
      err_seen_r <= err_seen_nxt;
      armed_r    <= armed_nxt;
      inside_r   <= inside_nxt;
      rec_pend_r <= rec_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_nib_r <= hi_nib_nxt;
    if (hdr_we) begin
      hdr_r[br_r[1:0]] <= byte_val;
    end
  end

endmodule

### design/ihx_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and the back of the parser.
// Depends on ihx_pkg.
module ihx_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ihx_pkg::cmd_t wdata,
  input  logic          pop,
  output ihx_pkg::cmd_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int PW = $clog2(ihx_pkg::QDEPTH);
  localparam int CNTW = $clog2(ihx_pkg::QDEPTH + 1);

  ihx_pkg::cmd_t   q_r [ihx_pkg::QDEPTH];
  logic [PW-1:0]   wp_r, wp_nxt;
  logic [PW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CNTW'(ihx_pkg::QDEPTH);
  assign empty = cnt_r == '0;
  assign rdata = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r + CNTW'(push) - CNTW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wdata;
    end
  end

endmodule

### design/ihx_back.sv
`timescale 1ns / 1ps
// Back of the parser: holds the line store and turns queued commands into
// result items through an output register. Depends on ihx_pkg and ihx_out_if.
module ihx_back #(
  parameter int LINE_BYTES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ihx_pkg::cmd_t                 cmd_data,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  output logic                          rec_done,
  input  logic                          mem_we,
  input  logic [$clog2(LINE_BYTES)-1:0] mem_waddr,
  input  logic [7:0]                    mem_wdata,
  ihx_out_if.source                     out_ch
);

  localparam int AW = $clog2(LINE_BYTES);

  logic [7:0]       mem [LINE_BYTES];
  logic [7:0]       rd_data_r;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic [8:0]       next_addr;

  ihx_pkg::bstate_t state_r, state_nxt;
  ihx_pkg::cmd_t    cur_r, cur_nxt;
  logic [7:0]       idx_r, idx_nxt;
  ihx_pkg::res_t    out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;
  logic             is_last;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign is_last   = (idx_r + 8'd1) == cur_r.len;
  assign next_addr = 9'(ihx_pkg::DATA_OFS) + 9'(idx_r) + 9'd1;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_pop       = 1'b0;
    rec_done      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = AW'(ihx_pkg::DATA_OFS);
    case (state_r)
      ihx_pkg::B_IDLE: begin
        if (!cmd_empty && slot_free) begin
          cmd_pop = 1'b1;
          out_nxt = '0;
          if (cmd_data.is_err) begin
            out_valid_nxt          = 1'b1;
            out_nxt.kind           = ihx_pkg::KIND_ERROR;
            out_nxt.record_type    = 8'hFF;
            out_nxt.last           = 1'b1;
            out_nxt.error_code     = cmd_data.code;
          end else if (cmd_data.len == 8'd0) begin
            out_valid_nxt          = 1'b1;
            out_nxt.kind           = ihx_pkg::KIND_EMPTY;
            out_nxt.record_type    = cmd_data.rtype;
            out_nxt.load_address   = cmd_data.addr;
            out_nxt.last           = 1'b1;
            rec_done               = 1'b1;
          end else begin
            cur_nxt   = cmd_data;
            idx_nxt   = 8'd0;
            rd_en     = 1'b1;
            state_nxt = ihx_pkg::B_DATA;
          end
        end
      end
      ihx_pkg::B_DATA: begin
        if (slot_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.kind          = ihx_pkg::KIND_DATA;
          out_nxt.record_type   = cur_r.rtype;
          out_nxt.record_length = cur_r.len[5:0];
          out_nxt.load_address  = cur_r.addr;
          out_nxt.data_value    = rd_data_r;
          out_nxt.byte_index    = idx_r[5:0];
          out_nxt.last          = is_last;
          out_nxt.error_code    = ihx_pkg::ERR_ODD;
          if (is_last) begin
            rec_done  = 1'b1;
            state_nxt = ihx_pkg::B_IDLE;
          end else begin
            idx_nxt = idx_r + 8'd1;
            rd_en   = 1'b1;
            rd_addr = next_addr[AW-1:0];
          end
        end
      end
      default: begin
        state_nxt = ihx_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ihx_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.record_type   = out_r.record_type;
  assign out_ch.record_length = out_r.record_length;
  assign out_ch.load_address  = out_r.load_address;
  assign out_ch.data_value    = out_r.data_value;
  assign out_ch.byte_index    = out_r.byte_index;
  assign out_ch.last          = out_r.last;
  assign out_ch.error_code    = out_r.error_code;

endmodule

### design/intel_hex_record_parser.sv
`timescale 1ns / 1ps
// Top level of the HEX record parser: front, command queue and back.
// Depends on ihx_pkg, ihx_if, ihx_front, ihx_cmd_fifo and ihx_back.
//
// The parser takes one character or session-start item per cycle while its
// input is not held. Error reports go through a two-entry command queue and
// hold the input only while that queue is full.
// The end-of-line character of a valid record holds the input until the
// record has drained from the line store: the first store read, then one
// data byte per cycle while results are taken. A line store of LINE_BYTES
// bytes holds the header, data and checksum; longer lines report an overflow.
module intel_hex_record_parser #(
  parameter int LINE_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ihx_in_if.sink    in_ch,
  ihx_out_if.source out_ch
);

  localparam int AW = $clog2(LINE_BYTES);

  ihx_pkg::cmd_t  push_data;
  ihx_pkg::cmd_t  pop_data;
  logic           cmd_push;
  logic           cmd_pop;
  logic           cmd_full;
  logic           cmd_empty;
  logic           rec_done;
  logic           rec_pending;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;

  ihx_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cmd_full   (cmd_full),
    .rec_done   (rec_done),
    .cmd_push   (cmd_push),
    .cmd_data   (push_data),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .rec_pending(rec_pending)
  );

  ihx_cmd_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cmd_push),
    .wdata(push_data),
    .pop  (cmd_pop),
    .rdata(pop_data),
    .full (cmd_full),
    .empty(cmd_empty)
  );

  ihx_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_data (pop_data),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .rec_done (rec_done),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .out_ch   (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !cmd_full)
    else $error("Command pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> !cmd_empty)
    else $error("Command popped from an empty queue.");

  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    rec_done |-> rec_pending)
    else $error("Record finished with no record outstanding.");

  a_no_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pending |-> !mem_we)
    else $error("Line store written while a record drains.");

endmodule
